// ----- rtl/lbp_pkg.sv -----
// Package for the block-interior LBP stream: widths, register indexes,
// reset values and the structs passed between the LBP submodules.
// No dependencies.
package lbp_pkg;

    // Line store geometry
    localparam int MAX_WIDTH = 256;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);

    // Field and register widths
    localparam int PIX_W  = 8;
    localparam int BLK_W  = 8;
    localparam int PH_W   = 4;
    localparam int LW_W   = 9;
    localparam int BS_W   = 5;
    localparam int WEFF_W = (ADDR_W + 1 > LW_W) ? ADDR_W + 1 : LW_W;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BLK_SIDE   = 1'b1;

    // Reset values and legal ranges
    localparam logic [LW_W-1:0] LW_RESET = 9'd100;
    localparam logic [BS_W-1:0] BS_RESET = 5'd10;
    localparam logic [LW_W-1:0] LW_MIN   = 9'd3;
    localparam logic [BS_W-1:0] BS_MIN   = 5'd3;
    localparam logic [BS_W-1:0] BS_MAX   = 5'd16;

    // Position information of one centre pixel
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              valid;
        logic [BLK_W-1:0]  bcol;
        logic [BLK_W-1:0]  brow;
    } t_pos;

    // One line-store entry: pixel two rows up and one row up
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
    } t_line_pair;

endpackage

// ----- rtl/lbp_cnt.sv -----
// Column/row counters and block phases for the incoming pixel.
// Produces the line-store address and block position of the centre.
// Depends on lbp_pkg.
module lbp_cnt import lbp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_frame_start,
    input  logic [LW_W-1:0]  i_line_width,
    input  logic [BS_W-1:0]  i_blk_side,
    output t_pos             o_pos
);

    typedef struct packed {
        logic [PH_W-1:0]  phase;
        logic [BLK_W-1:0] blk;
    } t_phase;

    logic [ADDR_W-1:0] r_col, n_col;
    logic              r_row_started, n_row_started;
    logic [PH_W-1:0]   r_cp, n_cp, r_rp, n_rp;
    logic [BLK_W-1:0]  r_bcc, n_bcc, r_brc, n_brc;

    logic [WEFF_W-1:0] w_eff;
    logic [BS_W-1:0]   bs_eff;
    logic [ADDR_W-1:0] col, c_sel;
    logic              started, last;
    logic [PH_W-1:0]   cp, rp;
    logic [BLK_W-1:0]  bcc, brc;
    t_phase            col_adv, row_adv;

    // Phase step with wrap at the block side and saturating block count
    function automatic t_phase advance(input logic [PH_W-1:0] phase,
                                       input logic [BLK_W-1:0] blk,
                                       input logic [BS_W-1:0] bs);
        t_phase           res;
        logic [BS_W-1:0]  p1;
        p1 = BS_W'(phase) + BS_W'(1);
        if (p1 >= bs) begin
            res.phase = '0;
            res.blk   = (blk == {BLK_W{1'b1}}) ? blk : blk + BLK_W'(1);
        end else begin
            res.phase = p1[PH_W-1:0];
            res.blk   = blk;
        end
        return res;
    endfunction

    // Clamp the registers to their usable ranges
    always_comb begin
        if (i_line_width < LW_MIN)
            w_eff = WEFF_W'(LW_MIN);
        else if (WEFF_W'(i_line_width) > WEFF_W'(MAX_WIDTH))
            w_eff = WEFF_W'(MAX_WIDTH);
        else
            w_eff = WEFF_W'(i_line_width);
        if (i_blk_side < BS_MIN)
            bs_eff = BS_MIN;
        else if (i_blk_side > BS_MAX)
            bs_eff = BS_MAX;
        else
            bs_eff = i_blk_side;
    end

    // Current position, after a frame start and a width wrap
    always_comb begin
        col     = i_frame_start ? '0   : r_col;
        started = i_frame_start ? 1'b0 : r_row_started;
        cp      = i_frame_start ? '0   : r_cp;
        rp      = i_frame_start ? '0   : r_rp;
        bcc     = i_frame_start ? '0   : r_bcc;
        brc     = i_frame_start ? '0   : r_brc;
        c_sel   = (WEFF_W'(col) >= w_eff) ? '0 : col;
        last    = (WEFF_W'(c_sel) + WEFF_W'(1)) >= w_eff;

        o_pos.addr  = c_sel;
        o_pos.valid = (cp != '0) && ((BS_W'(cp) + BS_W'(2)) <= bs_eff) &&
                      (rp != '0) && ((BS_W'(rp) + BS_W'(2)) <= bs_eff);
        o_pos.bcol  = bcc;
        o_pos.brow  = brc;
    end

    // Next counter state
    always_comb begin
        col_adv       = advance(cp, bcc, bs_eff);
        row_adv       = advance(rp, brc, bs_eff);
        n_row_started = started;
        n_rp          = rp;
        n_brc         = brc;
        if (last) begin
            n_col         = '0;
            n_cp          = '0;
            n_bcc         = '0;
            n_row_started = 1'b1;
            if (started) begin
                n_rp  = row_adv.phase;
                n_brc = row_adv.blk;
            end
        end else begin
            n_col = c_sel + ADDR_W'(1);
            n_cp  = cp;
            n_bcc = bcc;
            if (c_sel != '0) begin
                n_cp  = col_adv.phase;
                n_bcc = col_adv.blk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col         <= '0;
            r_row_started <= 1'b0;
            r_cp          <= '0;
            r_rp          <= '0;
            r_bcc         <= '0;
            r_brc         <= '0;
        end else if (i_step) begin
            r_col         <= n_col;
            r_row_started <= n_row_started;
            r_cp          <= n_cp;
            r_rp          <= n_rp;
            r_bcc         <= n_bcc;
            r_brc         <= n_brc;
        end
    end

endmodule

// ----- rtl/lbp_line_mem.sv -----
// Two-row line store: one synchronous memory, one entry per column holding
// the pixels one and two rows up, with per-entry valid bits and forwarding.
// Depends on lbp_pkg.
module lbp_line_mem import lbp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  t_line_pair        i_wr_data,
    output t_line_pair        o_rd_data
);

    t_line_pair           mem [MAX_WIDTH];
    logic [MAX_WIDTH-1:0] r_vld;
    t_line_pair           r_rd_data;
    logic                 r_rd_vld;
    logic                 r_fwd;
    t_line_pair           r_fwd_data;

    // Memory array: write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en)
            mem[i_wr_addr] <= i_wr_data;
        if (i_rd_en)
            r_rd_data <= mem[i_rd_addr];
    end

    // Valid bits: an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // Forward a write that lands on the entry read in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd    <= 1'b0;
            r_rd_vld <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd    <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en)
            r_fwd_data <= i_wr_data;
    end

    assign o_rd_data = r_fwd    ? r_fwd_data :
                       r_rd_vld ? r_rd_data  : '0;

endmodule

// ----- rtl/lbp_win.sv -----
// 3x3 window shift registers and the LBP code comparators.
// Centre is the middle pixel of the previous column.
// Depends on lbp_pkg.
module lbp_win import lbp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [PIX_W-1:0] i_top,
    input  logic [PIX_W-1:0] i_mid,
    input  logic [PIX_W-1:0] i_px,
    output logic [7:0]       o_code
);

    // [0..2]: previous column top/mid/bottom, [3..5]: the column before
    logic [PIX_W-1:0] r_win [6];
    logic [PIX_W-1:0] ctr;

    assign ctr = r_win[1];

    // Neighbours from top-left clockwise, MSB first
    assign o_code = {r_win[3] >= ctr, r_win[0] >= ctr, i_top >= ctr, i_mid >= ctr,
                     i_px >= ctr, r_win[2] >= ctr, r_win[5] >= ctr, r_win[4] >= ctr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++)
                r_win[i] <= '0;
        end else if (i_step) begin
            r_win[3] <= r_win[0];
            r_win[4] <= r_win[1];
            r_win[5] <= r_win[2];
            r_win[0] <= i_top;
            r_win[1] <= i_mid;
            r_win[2] <= i_px;
        end
    end

endmodule

// ----- rtl/lbp_block_interior_stream.sv -----
// LBP over block interiors; uses lbp_pkg, lbp_cnt, lbp_line_mem and lbp_win.
// Pipeline: an accepted pixel passes the line-store read stage, then the output
// register, where its result is held until it is taken.
// Throughput: one pixel per clock; the input stalls only while a result waits.
// Reset (synchronous, active low) clears counters, window, line-store valid bits
// and the pipeline; line_width returns to 100 and the block side to 10.
module lbp_block_interior_stream import lbp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [LW_W-1:0]      i_cfg_data,
    // Pixel input
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] pixel
    input  logic                 s_axis_tuser,   // [0] frame_start
    // Result output
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata,   // [7:0] code, [15:8] block_col,
                                                 // [23:16] block_row
    output logic                 m_axis_tuser    // [0] valid_res
);

    logic [LW_W-1:0]  r_line_width;
    logic [BS_W-1:0]  r_blk_side;

    logic             adv, accept, s1_move;
    t_pos             pos;
    logic             r_s1_valid;
    t_pos             r_s1_pos;
    logic [PIX_W-1:0] r_s1_px;
    t_line_pair       rd_pair, wr_pair;
    logic [7:0]       code;

    logic             r_out_valid;
    logic [23:0]      r_out_data, n_out_data;
    logic             r_out_user;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LW_RESET;
            r_blk_side   <= BS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LINE_WIDTH: r_line_width <= i_cfg_data;
                REG_BLK_SIDE:   r_blk_side   <= i_cfg_data[BS_W-1:0];
                default:        ;
            endcase
        end
    end

    // Pipeline advance: output register free or being taken
    assign adv           = !r_out_valid || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;
    assign s1_move       = adv && r_s1_valid;

    lbp_cnt u_cnt (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (accept),
        .i_frame_start (s_axis_tuser),
        .i_line_width  (r_line_width),
        .i_blk_side    (r_blk_side),
        .o_pos         (pos)
    );

    // Entry written back: old middle row moves up, new pixel becomes middle
    assign wr_pair.top = rd_pair.mid;
    assign wr_pair.mid = r_s1_px;

    lbp_line_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (pos.addr),
        .i_wr_en   (s1_move),
        .i_wr_addr (r_s1_pos.addr),
        .i_wr_data (wr_pair),
        .o_rd_data (rd_pair)
    );

    lbp_win u_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s1_move),
        .i_top   (rd_pair.top),
        .i_mid   (rd_pair.mid),
        .i_px    (r_s1_px),
        .o_code  (code)
    );

    // Read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pos <= pos;
            r_s1_px  <= s_axis_tdata;
        end
    end

    // Output register, fields zeroed outside block interiors
    assign n_out_data = r_s1_pos.valid ? {r_s1_pos.brow, r_s1_pos.bcol, code} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_data <= n_out_data;
            r_out_user <= r_s1_pos.valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

// ----- rtl/lbp_chk.sv -----
// Port-level checker for the LBP stream block, bound to the top level.
// No dependencies.
module lbp_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic [0:0]  i_cfg_index,
    input logic [8:0]  i_cfg_data,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Results outside a block interior carry zero fields
    a_zero_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 24'd0)
        else $error("invalid result with nonzero fields");

    // Every accepted pixel reaches the output register after the read stage
    a_latency: assert property (@(posedge i_clk)
        s_axis_tvalid && s_axis_tready && i_rst_n ##1 i_rst_n |=> m_axis_tvalid)
        else $error("accepted pixel produced no result");

    // Full, stalled output blocks the input
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while output stalled");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result present after reset");

endmodule

bind lbp_block_interior_stream lbp_chk u_lbp_chk (.*);
